// ----- hw/rtl/emna_pkg.sv -----
// Shared types, field widths, command codes and register indices of the extent map walker.
`timescale 1ns / 1ps
`default_nettype none
package emna_pkg;

   localparam int UNIT_W     = 40;
   localparam int BYTE_W     = 48;
   localparam int POS_W      = 49;
   localparam int COUNT_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int REQ_DATA_W = 136;
   localparam int CSR_DATA_W = 48;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_UNIT = 2'd1;
   localparam logic [1:0] CMD_BYTE = 2'd2;

   localparam logic [1:0] CSR_EXTENT_COUNT = 2'd0;
   localparam logic [1:0] CSR_UNIT_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_FILE_SIZE    = 2'd2;

   typedef struct packed {
      logic              hole;
      logic [UNIT_W-1:0] length;
      logic [UNIT_W-1:0] start;
   } entry_type;

endpackage
`default_nettype wire

// ----- hw/rtl/extent_map_next_allocated.sv -----
// Top level of the extent map walker: extent table memory, query sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// Extent table walker. A load beat writes one extent slot and leaves the request side ready. A
// unit query checks the position against the unit limit, reads the cursor extent, then steps
// past extents until one holds the position and, after a hole hit, reads on through the hole
// run; a position below the first extent answers without a walk and a position at or past the
// unit limit fails before the table is read. The walk is paced by the single read port of the
// extent memory, one entry per cycle. A byte query at or above zero takes an extra step to split
// the position into unit and offset; UNIT_BYTES must be a power of two. The request side reopens
// in the cycle the result beat appears, and a result that still waits there holds the next query
// in its last cycle. The table is not cleared after reset: slots must be loaded before a query
// reads them, and the block itself does not enforce it. The next request beat is taken while a
// finished result still waits on the response side.
module extent_map_next_allocated #(
   parameter int MAX_EXTENTS = 64,
   parameter int UNIT_BYTES  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, entry_start, entry_length, entry_hole, position
   input  logic [emna_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_position
   output logic [emna_pkg::BYTE_W-1:0]       rsp_tdata,
   // found
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [emna_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int IW  = $clog2(MAX_EXTENTS);
   localparam int CW  = $clog2(MAX_EXTENTS + 1);
   localparam int RW  = $clog2(UNIT_BYTES);
   localparam int PW  = emna_pkg::UNIT_W + 1 + RW;
   localparam int UW  = emna_pkg::UNIT_W;
   localparam int BW  = emna_pkg::BYTE_W;
   localparam int PSW = emna_pkg::POS_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_CUR  = 4'd4;
   localparam logic [3:0] ST_WALK = 4'd5;
   localparam logic [3:0] ST_HOLE = 4'd6;
   localparam logic [3:0] ST_MUL  = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;

   logic [emna_pkg::INDEX_W-1:0] req_entry_index;
   logic [UW-1:0]                req_entry_start;
   logic [UW-1:0]                req_entry_length;
   logic                         req_entry_hole;
   logic [PSW-1:0]               req_position;

   assign req_entry_index  = req_tdata[5:0];
   assign req_entry_start  = req_tdata[45:6];
   assign req_entry_length = req_tdata[85:46];
   assign req_entry_hole   = req_tdata[86];
   assign req_position     = req_tdata[135:87];

   emna_pkg::entry_type mem [MAX_EXTENTS];
   emna_pkg::entry_type rd_data;
   emna_pkg::entry_type wr_entry;
   logic [IW-1:0]       rd_addr;
   logic [IW-1:0]       wr_addr;
   logic                mem_we;

   logic [3:0]                   state_ff, state_in;
   logic [emna_pkg::COUNT_W-1:0] ext_count_ff, ext_count_in;
   logic [UW-1:0]                unit_limit_ff, unit_limit_in;
   logic [BW-1:0]                file_size_ff, file_size_in;
   logic [UW-1:0]                start0_ff, start0_in;
   logic [UW-1:0]                start1_ff, start1_in;
   logic [IW-1:0]                cursor_ff, cursor_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [CW-1:0]                c_ff, c_in;
   logic [PSW-1:0]               nxt_ff, nxt_in;
   logic                         huge_ff, huge_in;
   logic [UW:0]                  end_ff, end_in;
   logic [UW:0]                  u_ff, u_in;
   logic                         ok_ff, ok_in;
   logic                         byte_ff, byte_in;
   logic                         cmp_ff, cmp_in;
   logic [BW-1:0]                num_ff, num_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [PSW-1:0]               posp1_ff, posp1_in;
   logic [PW-1:0]                prod_ff, prod_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [BW-1:0]                rsp_pos_ff, rsp_pos_in;

   logic          req_fire;
   logic [CW-1:0] cnt_eff;
   logic [CW-1:0] c_nx;
   logic          nxt_ok;
   logic [UW:0]   ext_end;
   logic          hit;
   logic [IW-1:0] cur_pick;
   logic [BW-1:0] result;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_found_ff;

   assign cnt_eff = (32'(ext_count_ff) > MAX_EXTENTS) ? CW'(MAX_EXTENTS) : CW'(ext_count_ff);
   assign c_nx    = c_ff + CW'(1);
   assign nxt_ok  = (c_nx < cnt_ff);
   assign ext_end = {1'b0, rd_data.start} + {1'b0, rd_data.length};
   assign hit     = (nxt_ff >= PSW'(rd_data.start)) && (nxt_ff < PSW'(ext_end));
   assign cur_pick = (nxt_ff < PSW'(rd_data.start)) ? '0 : cursor_ff;

   assign mem_we   = req_fire && (req_tuser == emna_pkg::CMD_LOAD) &&
                     (32'(req_entry_index) < MAX_EXTENTS);
   assign wr_addr  = IW'(req_entry_index);
   assign wr_entry = '{hole: req_entry_hole, length: req_entry_length, start: req_entry_start};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

   always_comb begin
      if (!ok_ff) begin
         result = '0;
      end else if (!byte_ff) begin
         result = BW'(u_ff);
      end else if (cmp_ff && (BW'(u_ff) == num_ff)) begin
         result = posp1_ff[BW-1:0];
      end else begin
         result = prod_ff[BW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      ext_count_in  = ext_count_ff;
      unit_limit_in = unit_limit_ff;
      file_size_in  = file_size_ff;
      start0_in     = start0_ff;
      start1_in     = start1_ff;
      cursor_in     = cursor_ff;
      cnt_in        = cnt_ff;
      c_in          = c_ff;
      nxt_in        = nxt_ff;
      huge_in       = huge_ff;
      end_in        = end_ff;
      u_in          = u_ff;
      ok_in         = ok_ff;
      byte_in       = byte_ff;
      cmp_in        = cmp_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      posp1_in      = posp1_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rd_addr       = '0;

      if (csr_valid) begin
         unique case (csr_index)
            emna_pkg::CSR_EXTENT_COUNT: ext_count_in  = csr_data[emna_pkg::COUNT_W-1:0];
            emna_pkg::CSR_UNIT_LIMIT:   unit_limit_in = csr_data[UW-1:0];
            emna_pkg::CSR_FILE_SIZE:    file_size_in  = csr_data[BW-1:0];
            default: ;
         endcase
      end

      if (mem_we && (req_entry_index == emna_pkg::INDEX_W'(0))) begin
         start0_in = req_entry_start;
      end
      if (mem_we && (req_entry_index == emna_pkg::INDEX_W'(1))) begin
         start1_in = req_entry_start;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = cnt_eff;
               unique case (req_tuser)
                  emna_pkg::CMD_UNIT: begin
                     byte_in  = 1'b0;
                     cmp_in   = 1'b0;
                     huge_in  = req_position[PSW-1] && (req_position != '1);
                     nxt_in   = req_position[PSW-1] ? '0
                                : {1'b0, req_position[BW-1:0]} + PSW'(1);
                     state_in = ST_CHK;
                  end
                  emna_pkg::CMD_BYTE: begin
                     byte_in  = 1'b1;
                     huge_in  = 1'b0;
                     cmp_in   = 1'b0;
                     nxt_in   = '0;
                     num_in   = {{RW{1'b0}}, req_position[BW-1:RW]};
                     rem_in   = req_position[RW-1:0];
                     posp1_in = {1'b0, req_position[BW-1:0]} + PSW'(1);
                     state_in = req_position[PSW-1] ? ST_CHK : ST_PREP;
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            if (posp1_ff >= PSW'(file_size_ff)) begin
               ok_in    = 1'b0;
               state_in = ST_FIN;
            end else begin
               if (rem_ff == RW'(UNIT_BYTES - 1)) begin
                  nxt_in = PSW'(num_ff) + PSW'(1);
                  cmp_in = 1'b0;
               end else begin
                  nxt_in = PSW'(num_ff);
                  cmp_in = 1'b1;
               end
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (huge_ff || (nxt_ff >= PSW'(unit_limit_ff))) begin
               ok_in    = 1'b0;
               state_in = ST_FIN;
            end else begin
               rd_addr  = cursor_ff;
               state_in = ST_CUR;
            end
         end
         ST_CUR: begin
            cursor_in = cur_pick;
            if (nxt_ff < PSW'(start0_ff)) begin
               u_in     = {1'b0, start1_ff};
               ok_in    = 1'b1;
               state_in = ST_MUL;
            end else begin
               c_in     = CW'(cur_pick);
               rd_addr  = cur_pick;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit) begin
               if (rd_data.hole && nxt_ok) begin
                  end_in   = ext_end;
                  c_in     = c_nx;
                  rd_addr  = IW'(c_nx);
                  state_in = ST_HOLE;
               end else begin
                  u_in      = rd_data.hole ? ext_end : nxt_ff[UW:0];
                  cursor_in = IW'(c_ff);
                  ok_in     = 1'b1;
                  state_in  = ST_MUL;
               end
            end else if (nxt_ok) begin
               c_in    = c_nx;
               rd_addr = IW'(c_nx);
            end else begin
               cursor_in = '0;
               ok_in     = 1'b0;
               state_in  = ST_FIN;
            end
         end
         ST_HOLE: begin
            if (rd_data.hole) begin
               if (nxt_ok) begin
                  end_in  = ext_end;
                  c_in    = c_nx;
                  rd_addr = IW'(c_nx);
               end else begin
                  u_in      = ext_end;
                  cursor_in = IW'(c_ff);
                  ok_in     = 1'b1;
                  state_in  = ST_MUL;
               end
            end else begin
               u_in      = end_ff;
               cursor_in = IW'(c_ff - CW'(1));
               ok_in     = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = {u_ff, {RW{1'b0}}};
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = ok_ff;
               rsp_pos_in   = result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ext_count_ff  <= emna_pkg::COUNT_W'(2);
         unit_limit_ff <= '0;
         file_size_ff  <= '0;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ext_count_ff  <= ext_count_in;
         unit_limit_ff <= unit_limit_in;
         file_size_ff  <= file_size_in;
         cursor_ff     <= cursor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start0_ff    <= start0_in;
      start1_ff    <= start1_in;
      cnt_ff       <= cnt_in;
      c_ff         <= c_in;
      nxt_ff       <= nxt_in;
      huge_ff      <= huge_in;
      end_ff       <= end_in;
      u_ff         <= u_in;
      ok_ff        <= ok_in;
      byte_ff      <= byte_in;
      cmp_ff       <= cmp_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      posp1_ff     <= posp1_in;
      prod_ff      <= prod_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/emna_checker.sv -----
// Port-level checks of the extent map walker and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module emna_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [emna_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic [1:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [emna_pkg::BYTE_W-1:0]       rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [1:0]                        csr_index,
   input logic [emna_pkg::CSR_DATA_W-1:0]   csr_data
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("miss beat carries a nonzero position");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_tuser == emna_pkg::CMD_UNIT || req_tuser == emna_pkg::CMD_BYTE))
      |=> !req_tready)
      else $error("query beat did not hold off the next request");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == emna_pkg::CMD_LOAD) |=> req_tready)
      else $error("load beat stalled the request side");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

endmodule

bind extent_map_next_allocated emna_checker u_emna_checker (.*);
`default_nettype wire

// ----- tb/sv/extent_map_next_allocated_test.sv -----
// Self-checking testbench of the extent map walker: table loads and unit/byte queries.
`timescale 1ns / 1ps
module extent_map_next_allocated_test;

   localparam int UNIT_W     = emna_pkg::UNIT_W;
   localparam int BYTE_W     = emna_pkg::BYTE_W;
   localparam int POS_W      = emna_pkg::POS_W;
   localparam int COUNT_W    = emna_pkg::COUNT_W;
   localparam int INDEX_W    = emna_pkg::INDEX_W;
   localparam int REQ_DATA_W = emna_pkg::REQ_DATA_W;
   localparam int CSR_DATA_W = emna_pkg::CSR_DATA_W;

   localparam int TABLE_DEPTH  = 64;
   localparam int UNIT_BYTES   = 1024;
   localparam int CLOCK_PERIOD = 10;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int RUN_LIMIT    = 1000000;

   localparam logic [1:0]        CMD_NONE   = 2'd3;
   localparam logic [UNIT_W-1:0] UNIT_MAX   = '1;
   localparam logic [BYTE_W-1:0] BYTE_MAX   = '1;
   localparam logic [POS_W-1:0]  POS_BEFORE = '1;
   localparam logic [POS_W-1:0]  POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};

   typedef struct {
      bit                found;
      logic [BYTE_W-1:0] next_position;
   } answer_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   logic steady       = 1'b0;
   logic rsp_hold_req = 1'b0;
   int   hold_left    = 0;
   int   cycle_count  = 0;
   int   error_count  = 0;

   // model of the extent table, cursor and registers
   logic [UNIT_W-1:0]  tbl_start  [TABLE_DEPTH];
   logic [UNIT_W-1:0]  tbl_length [TABLE_DEPTH];
   logic               tbl_hole   [TABLE_DEPTH];
   int                 walk_cursor    = 0;
   logic [COUNT_W-1:0] cfg_count      = 7'd2;
   logic [UNIT_W-1:0]  cfg_unit_limit = '0;
   logic [BYTE_W-1:0]  cfg_file_size  = '0;
   answer_type         pending_answers [$];
   answer_type         rsp_want;

   bit          unit_seq_found = 1'b0;
   logic [63:0] unit_seq       = '0;
   bit          byte_seq_found = 1'b0;
   logic [63:0] byte_seq       = '0;
   int          layout_span    = 2;
   logic [63:0] layout_end     = '0;

   extent_map_next_allocated #(
      .MAX_EXTENTS(TABLE_DEPTH),
      .UNIT_BYTES (UNIT_BYTES)
   ) dut (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected beat: found %0b next_position %0h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            rsp_want = pending_answers.pop_front();
            if (rsp_tuser !== rsp_want.found) begin
               $error("found: expected %0b, actual %0b", rsp_want.found, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== rsp_want.next_position) begin
               $error("next_position: expected %0h, actual %0h",
                      rsp_want.next_position, rsp_tdata);
               error_count++;
            end
         end
      end
      if (rsp_hold_req)
         hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= 24;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit idle_roll();
      return !steady && $urandom_range(99) < 24;
   endfunction

   function automatic bit next_unit_after(input logic [63:0] probe, output logic [63:0] answer);
      int          span;
      int          slot;
      logic [63:0] lo;
      logic [63:0] hi;
      answer = '0;
      if (probe >= 64'(cfg_unit_limit))
         return 1'b0;
      span = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
      if (probe < 64'(tbl_start[walk_cursor]))
         walk_cursor = 0;
      if (probe < 64'(tbl_start[0])) begin
         answer = 64'(tbl_start[1]);
         return 1'b1;
      end
      slot = walk_cursor;
      do begin
         lo = 64'(tbl_start[slot]);
         hi = lo + 64'(tbl_length[slot]);
         if (probe >= lo && probe < hi) begin
            if (tbl_hole[slot]) begin
               while (slot + 1 < span && tbl_hole[slot + 1])
                  slot++;
               probe = 64'(tbl_start[slot]) + 64'(tbl_length[slot]);
            end
            walk_cursor = slot;
            answer = probe;
            return 1'b1;
         end
         slot++;
      end while (slot < span);
      walk_cursor = 0;
      return 1'b0;
   endfunction

   function automatic void apply_item(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                                      input logic [UNIT_W-1:0] start,
                                      input logic [UNIT_W-1:0] len, input logic hole,
                                      input logic [POS_W-1:0] pos);
      logic [63:0] pos_wide;
      logic [63:0] whole;
      logic [63:0] unit;
      logic [63:0] reply;
      bit          hit;
      answer_type  ans;
      pos_wide = 64'(pos);
      unit = '0;
      reply = '0;
      hit = 1'b0;
      case (cmd)
         emna_pkg::CMD_LOAD: begin
            tbl_start[idx]  = start;
            tbl_length[idx] = len;
            tbl_hole[idx]   = hole;
            return;
         end
         emna_pkg::CMD_UNIT: begin
            hit = next_unit_after({{(64-POS_W){pos[POS_W-1]}}, pos} + 64'd1, unit);
            reply = unit;
            unit_seq_found = hit;
            unit_seq = unit;
         end
         emna_pkg::CMD_BYTE: begin
            whole = pos_wide / 64'(UNIT_BYTES);
            if (pos[POS_W-1]) begin
               hit = next_unit_after(64'd0, unit);
               reply = unit * 64'(UNIT_BYTES);
            end else if (pos_wide + 64'd1 >= 64'(cfg_file_size)) begin
               hit = 1'b0;
            end else if ((pos_wide + 64'd1) % 64'(UNIT_BYTES) == 64'd0) begin
               hit = next_unit_after(whole + 64'd1, unit);
               reply = unit * 64'(UNIT_BYTES);
            end else begin
               hit = next_unit_after(whole, unit);
               reply = (unit == whole) ? pos_wide + 64'd1 : unit * 64'(UNIT_BYTES);
            end
            byte_seq_found = hit;
            byte_seq = reply;
         end
         default: return;
      endcase
      ans.found = hit;
      ans.next_position = hit ? reply[BYTE_W-1:0] : '0;
      pending_answers.push_back(ans);
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                            input logic [UNIT_W-1:0] start, input logic [UNIT_W-1:0] len,
                            input logic hole, input logic [POS_W-1:0] pos);
      while (idle_roll()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pos, hole, len, start, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_item(cmd, idx, start, len, hole, pos);
   endtask

   task automatic send_query(input logic [1:0] cmd, input logic [POS_W-1:0] pos);
      send_item(cmd, 6'($urandom), 40'(rand64()), 40'(rand64()), 1'($urandom), pos);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         emna_pkg::CSR_EXTENT_COUNT: cfg_count = value[COUNT_W-1:0];
         emna_pkg::CSR_UNIT_LIMIT:   cfg_unit_limit = value[UNIT_W-1:0];
         emna_pkg::CSR_FILE_SIZE:    cfg_file_size = value[BYTE_W-1:0];
         default:                    ;
      endcase
   endtask

   task automatic configure(input logic [COUNT_W-1:0] count, input logic [UNIT_W-1:0] limit,
                            input logic [BYTE_W-1:0] size);
      write_register(emna_pkg::CSR_EXTENT_COUNT, CSR_DATA_W'(count));
      write_register(emna_pkg::CSR_UNIT_LIMIT, CSR_DATA_W'(limit));
      write_register(emna_pkg::CSR_FILE_SIZE, size);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sorted extents with small gaps, runs of holes and the odd empty extent
   task automatic load_layout(input int span, input logic [UNIT_W-1:0] base);
      int                slot;
      logic [UNIT_W-1:0] at;
      logic [UNIT_W-1:0] len;
      bit                hole_run;
      at = base;
      hole_run = 1'b0;
      for (slot = 0; slot < span; slot++) begin
         if ($urandom_range(3) == 0)
            at = at + UNIT_W'($urandom_range(1, 8));
         len = ($urandom_range(15) == 0) ? '0 : UNIT_W'($urandom_range(1, 24));
         hole_run = hole_run ? ($urandom_range(1) == 1) : ($urandom_range(3) == 0);
         send_item(emna_pkg::CMD_LOAD, 6'(slot), at, len, hole_run, 49'(rand64()));
         at = at + len;
      end
      layout_span = span;
      layout_end = 64'(at);
   endtask

   function automatic logic [63:0] unit_near_extent();
      int slot;
      slot = int'($urandom_range(layout_span - 1));
      return 64'(tbl_start[slot]) + 64'($urandom_range(32)) - 64'd3;
   endfunction

   function automatic logic [POS_W-1:0] pick_unit_position();
      logic [63:0] u;
      logic [63:0] r;
      r = rand64();
      case ($urandom_range(9))
         0, 1, 2, 3: u = unit_near_extent();
         4, 5:       u = unit_seq_found ? unit_seq : '1;
         6:          u = 64'(cfg_unit_limit) + 64'($urandom_range(3)) - 64'd3;
         7:          u = '1;
         8:          u = {16'hFFFF, r[47:0]};
         default:    u = r;
      endcase
      return u[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] pick_byte_position();
      logic [63:0] u;
      logic [63:0] r;
      r = rand64();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            u = unit_near_extent() * 64'(UNIT_BYTES);
            case ($urandom_range(3))
               0:       u = u + 64'(UNIT_BYTES) - 64'd1;
               1:       u = u + 64'(UNIT_BYTES) - 64'd2;
               2:       u = u + 64'($urandom_range(UNIT_BYTES - 1));
               default: u = u + 64'd1;
            endcase
         end
         5, 6:    u = byte_seq_found ? byte_seq : '1;
         7:       u = 64'(cfg_file_size) + 64'($urandom_range(3)) - 64'd3;
         8:       u = {16'hFFFF, r[47:0]};
         default: u = r;
      endcase
      return u[POS_W-1:0];
   endfunction

   task automatic run_queries(input int n);
      int          k;
      int          roll;
      logic [63:0] r;
      for (k = 0; k < n; k++) begin
         roll = int'($urandom_range(99));
         r = rand64();
         if (roll < 45)
            send_query(emna_pkg::CMD_UNIT, pick_unit_position());
         else if (roll < 90)
            send_query(emna_pkg::CMD_BYTE, pick_byte_position());
         else if (roll < 95)
            send_item(emna_pkg::CMD_LOAD, 6'($urandom), r[UNIT_W-1:0], 40'(rand64()), r[63],
                      49'(rand64()));
         else
            send_query(CMD_NONE, 49'(rand64()));
      end
   endtask

   task automatic test_directed();
      // registers at reset: every query fails before touching the table
      send_query(emna_pkg::CMD_UNIT, POS_BEFORE);
      send_query(emna_pkg::CMD_BYTE, 49'd5000);
      send_query(emna_pkg::CMD_BYTE, POS_BEFORE);
      send_item(emna_pkg::CMD_LOAD, 6'd0, 40'd10, 40'd5, 1'b0, '0);
      send_item(emna_pkg::CMD_LOAD, 6'd1, 40'd15, 40'd3, 1'b1, '0);
      send_item(emna_pkg::CMD_LOAD, 6'd2, 40'd18, 40'd2, 1'b1, '0);
      send_item(emna_pkg::CMD_LOAD, 6'd3, 40'd20, 40'd10, 1'b0, '0);
      send_item(emna_pkg::CMD_LOAD, 6'd63, UNIT_MAX, UNIT_MAX, 1'b1, POS_MAX);
      layout_span = 4;
      drain_results();
      configure(7'd4, 40'd40, 48'd31220);
      send_query(emna_pkg::CMD_UNIT, POS_BEFORE);
      send_query(emna_pkg::CMD_UNIT, 49'd9);
      send_query(emna_pkg::CMD_UNIT, 49'd14);
      send_query(emna_pkg::CMD_UNIT, 49'd29);
      send_query(emna_pkg::CMD_UNIT, 49'd39);
      send_query(emna_pkg::CMD_UNIT, POS_MIN);
      send_query(emna_pkg::CMD_UNIT, POS_MAX);
      send_query(emna_pkg::CMD_BYTE, POS_BEFORE);
      send_query(emna_pkg::CMD_BYTE, POS_MIN);
      send_query(emna_pkg::CMD_BYTE, 49'(10 * UNIT_BYTES + 100));
      send_query(emna_pkg::CMD_BYTE, 49'(11 * UNIT_BYTES - 1));
      send_query(emna_pkg::CMD_BYTE, 49'(15 * UNIT_BYTES - 1));
      send_query(emna_pkg::CMD_BYTE, 49'd31219);
      send_query(emna_pkg::CMD_BYTE, POS_MAX);
      send_query(CMD_NONE, POS_BEFORE);
   endtask

   task automatic test_extremes();
      load_layout(TABLE_DEPTH, 40'hFF_FFFF_E000);
      drain_results();
      configure(7'h7F, UNIT_MAX, BYTE_MAX);
      send_query(emna_pkg::CMD_BYTE, POS_BEFORE);
      run_queries(20);
      drain_results();
      configure(7'd0, layout_end[UNIT_W-1:0], BYTE_W'(layout_end * 64'(UNIT_BYTES)));
      run_queries(15);
      drain_results();
      configure(7'd1, '0, '0);
      run_queries(10);
      drain_results();
      configure(7'd64, layout_end[UNIT_W-1:0] + 40'd5, 48'd1);
      run_queries(15);
   endtask

   task automatic test_backpressure();
      steady <= 1'b1;
      rsp_hold_req <= 1'b1;
      run_queries(1);
      rsp_hold_req <= 1'b0;
      run_queries(40);
      steady <= 1'b0;
   endtask

   task automatic test_random();
      int                phase;
      int                roll;
      int                count;
      int                span;
      logic [63:0]       r;
      logic [63:0]       scaled;
      logic [UNIT_W-1:0] base;
      logic [UNIT_W-1:0] limit;
      logic [BYTE_W-1:0] size;
      for (phase = 0; phase < 10; phase++) begin
         drain_results();
         steady <= (phase == 3);
         roll = int'($urandom_range(9));
         if (roll < 6)
            count = int'($urandom_range(2, 16));
         else if (roll < 8)
            count = int'($urandom_range(17, 64));
         else if (roll == 8)
            count = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 1 : 64);
         else
            count = int'($urandom_range(65, 127));
         span = (count > TABLE_DEPTH) ? TABLE_DEPTH : ((count < 2) ? 2 : count);

         r = rand64();
         roll = int'($urandom_range(9));
         if (roll < 5)
            base = UNIT_W'($urandom_range(200));
         else if (roll < 8)
            base = {1'b0, r[UNIT_W-2:0]};
         else
            base = 40'hFF_FFFF_F000 - UNIT_W'($urandom_range(1000));
         load_layout(span, base);
         drain_results();

         r = rand64();
         roll = int'($urandom_range(9));
         if (roll < 5)
            limit = layout_end[UNIT_W-1:0];
         else if (roll < 7)
            limit = layout_end[UNIT_W-1:0] + UNIT_W'($urandom_range(40));
         else if (roll == 7)
            limit = tbl_start[span / 2];
         else if (roll == 8)
            limit = r[UNIT_W-1:0];
         else
            limit = ($urandom_range(1) == 1) ? UNIT_MAX : '0;

         scaled = 64'(limit) * 64'(UNIT_BYTES);
         roll = int'($urandom_range(9));
         if (roll < 6)
            scaled = scaled - 64'($urandom_range(UNIT_BYTES - 1));
         else if (roll < 8)
            scaled = scaled + 64'($urandom_range(4 * UNIT_BYTES));
         else if (roll == 8)
            scaled = {16'd0, r[63:16]};
         else
            scaled = 64'(BYTE_MAX);
         size = (scaled > 64'(BYTE_MAX)) ? BYTE_MAX : scaled[BYTE_W-1:0];

         configure(7'(count), limit, size);
         run_queries(65);
      end
      steady <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_extremes();
      test_backpressure();
      test_random();
      drain_results();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/emna_pkg.sv
hw/rtl/extent_map_next_allocated.sv
hw/rtl/emna_checker.sv
tb/sv/extent_map_next_allocated_test.sv
